[design/cgw_pkg.sv]
// Shared widths, constants and lookup functions for the calendar to GPS week converter.
`timescale 1ns / 1ps

package cgw_pkg;

  // Field widths
  localparam int unsigned YearW    = 12;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinuteW  = 6;
  localparam int unsigned SecMsW   = 16;
  localparam int unsigned WeekW    = 17;
  localparam int unsigned TowW     = 30;

  // Internal widths
  localparam int unsigned DaysW    = 20;  // day count from 1 Jan 1980
  localparam int unsigned Q100W    = 6;   // quotient of a 12-bit value by 100
  localparam int unsigned HourMsW  = 27;
  localparam int unsigned MinMsW   = 22;
  localparam int unsigned LeapW    = 11;

  // Calendar constants
  localparam int unsigned EpochYear        = 1980;
  localparam int unsigned EpochDayOffset   = 6;     // 6 Jan 1980 is day zero
  localparam int unsigned LeapsBeforeEpoch = 479;   // leap years in 1..1979
  localparam int unsigned DaysPerYear      = 365;
  localparam int unsigned MsPerDay         = 86400000;
  localparam int unsigned MsPerHour        = 3600000;
  localparam int unsigned MsPerMin         = 60000;

  // Reciprocals: x/100 = (x*5243)>>19 for x < 4096, x/7 = (x*1198373)>>23 for x < 2^20
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Recip7        = 1198373;
  localparam int unsigned Recip7Shift   = 23;

  // Days before the first of each month in a common year
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
    logic [8:0] d;
    case (month)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Milliseconds at the start of each weekday
  function automatic logic [TowW-1:0] weekday_ms(input logic [2:0] wday);
    logic [TowW-1:0] ms;
    case (wday)
      3'd1:    ms = TowW'(1 * MsPerDay);
      3'd2:    ms = TowW'(2 * MsPerDay);
      3'd3:    ms = TowW'(3 * MsPerDay);
      3'd4:    ms = TowW'(4 * MsPerDay);
      3'd5:    ms = TowW'(5 * MsPerDay);
      3'd6:    ms = TowW'(6 * MsPerDay);
      default: ms = '0;
    endcase
    return ms;
  endfunction

endpackage

[design/cgw_in_if.sv]
// Input channel: calendar date and time with valid/ready handshake.
`timescale 1ns / 1ps

interface cgw_in_if;
  logic                          valid;
  logic                          ready;
  logic [cgw_pkg::YearW-1:0]     year;
  logic [cgw_pkg::MonthW-1:0]    month;
  logic [cgw_pkg::DayW-1:0]      day;
  logic [cgw_pkg::HourW-1:0]     hour;
  logic [cgw_pkg::MinuteW-1:0]   minute;
  logic [cgw_pkg::SecMsW-1:0]    second_ms;

  modport source (output valid, year, month, day, hour, minute, second_ms, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second_ms, output ready);
endinterface

[design/cgw_out_if.sv]
// Output channel: GPS week, time of week and invalid flag with valid/ready handshake.
`timescale 1ns / 1ps

interface cgw_out_if;
  logic                         valid;
  logic                         ready;
  logic [cgw_pkg::WeekW-1:0]    gps_week;
  logic [cgw_pkg::TowW-1:0]     week_time_ms;
  logic                         date_invalid;

  modport source (output valid, gps_week, week_time_ms, date_invalid, input ready);
  modport sink   (input valid, gps_week, week_time_ms, date_invalid, output ready);
endinterface

[design/calendar_to_gps_week_time.sv]
// Calendar date/time to GPS week and time-of-week converter, four-stage pipeline.
// A result passes through the stage 1 to stage 4 registers in turn before it is offered
// at the output.
// Throughput: one transaction per cycle; each stage stalls only when it is full and
// the stage after it cannot take its contents, so bubbles are squeezed out.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module calendar_to_gps_week_time (
  input  logic         clk_i,
  input  logic         rst_ni,
  cgw_in_if.sink       in_i,
  cgw_out_if.source    out_o
);

  // Stage valid bits and per-stage advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // ---------------- Stage 1: field checks, /100 quotients, hour/minute products
  logic [cgw_pkg::YearW-1:0]   n_in;
  logic [24:0]                 qn_prod, qy_prod;
  logic                        fbad_s1;
  logic [cgw_pkg::HourMsW-1:0] hour_ms_s1;
  logic [cgw_pkg::MinMsW-1:0]  min_ms_s1;

  assign n_in    = in_i.year - cgw_pkg::YearW'(1);
  assign qn_prod = 25'(n_in) * 25'(cgw_pkg::Recip100);
  assign qy_prod = 25'(in_i.year) * 25'(cgw_pkg::Recip100);
  assign fbad_s1 = (in_i.year < cgw_pkg::YearW'(cgw_pkg::EpochYear)) ||
                   (in_i.month == '0) || (in_i.month > cgw_pkg::MonthW'(12)) ||
                   (in_i.day == '0);
  assign hour_ms_s1 = cgw_pkg::HourMsW'(in_i.hour) * cgw_pkg::HourMsW'(cgw_pkg::MsPerHour);
  assign min_ms_s1  = cgw_pkg::MinMsW'(in_i.minute) * cgw_pkg::MinMsW'(cgw_pkg::MsPerMin);

  logic [cgw_pkg::YearW-1:0]   year1_q;
  logic [cgw_pkg::MonthW-1:0]  month1_q;
  logic [cgw_pkg::DayW-1:0]    day1_q;
  logic                        bad1_q;
  logic [cgw_pkg::Q100W-1:0]   qn1_q, qy1_q;
  logic [cgw_pkg::HourMsW-1:0] hour_ms1_q;
  logic [cgw_pkg::MinMsW-1:0]  min_ms1_q;
  logic [cgw_pkg::SecMsW-1:0]  sec1_q;

  // ---------------- Stage 2: leap test and day count since 1 Jan 1980
  logic [cgw_pkg::YearW-1:0] n2, yo2, c100;
  logic [cgw_pkg::LeapW-1:0] leaps2;
  logic                      div4, div100, leap2, leap_adj2;
  logic [cgw_pkg::DaysW-1:0] days_s2;
  logic [cgw_pkg::TowW-1:0]  tp_s2;

  assign n2     = year1_q - cgw_pkg::YearW'(1);
  assign yo2    = year1_q - cgw_pkg::YearW'(cgw_pkg::EpochYear);
  assign leaps2 = cgw_pkg::LeapW'(n2[cgw_pkg::YearW-1:2]) - cgw_pkg::LeapW'(qn1_q)
                + cgw_pkg::LeapW'(qn1_q[cgw_pkg::Q100W-1:2]);
  assign c100   = cgw_pkg::YearW'(qy1_q) * cgw_pkg::YearW'(100);
  assign div4   = (year1_q[1:0] == 2'b00);
  assign div100 = (year1_q == c100);
  assign leap2  = (div4 && !div100) || (div100 && (qy1_q[1:0] == 2'b00));
  assign leap_adj2 = leap2 && (month1_q > cgw_pkg::MonthW'(2));
  assign days_s2 = cgw_pkg::DaysW'(yo2) * cgw_pkg::DaysW'(cgw_pkg::DaysPerYear)
                 + cgw_pkg::DaysW'(leaps2)
                 + cgw_pkg::DaysW'(cgw_pkg::days_before_month(month1_q))
                 + cgw_pkg::DaysW'(leap_adj2)
                 + cgw_pkg::DaysW'(day1_q)
                 - cgw_pkg::DaysW'(cgw_pkg::LeapsBeforeEpoch);
  assign tp_s2 = cgw_pkg::TowW'(hour_ms1_q) + cgw_pkg::TowW'(min_ms1_q)
               + cgw_pkg::TowW'(sec1_q);

  logic [cgw_pkg::DaysW-1:0] days2_q;
  logic [cgw_pkg::TowW-1:0]  tp2_q;
  logic                      bad2_q;

  // ---------------- Stage 3: epoch check and week by reciprocal of 7
  logic                      before_s3;
  logic [cgw_pkg::DaysW-1:0] d6_s3;
  logic [40:0]               wprod;

  assign before_s3 = days2_q < cgw_pkg::DaysW'(cgw_pkg::EpochDayOffset);
  assign d6_s3     = days2_q - cgw_pkg::DaysW'(cgw_pkg::EpochDayOffset);
  assign wprod     = 41'(d6_s3) * 41'(cgw_pkg::Recip7);

  logic [cgw_pkg::WeekW-1:0] week3_q;
  logic [cgw_pkg::DaysW-1:0] d63_q;
  logic [cgw_pkg::TowW-1:0]  tp3_q;
  logic                      bad3_q;

  // ---------------- Stage 4: weekday remainder and time of week
  logic [cgw_pkg::DaysW-1:0] w7_s4;
  logic [2:0]                wday_s4;
  logic [cgw_pkg::TowW-1:0]  tow_s4;

  assign w7_s4   = {week3_q, 3'b000} - cgw_pkg::DaysW'(week3_q);
  assign wday_s4 = d63_q[2:0] - w7_s4[2:0];
  assign tow_s4  = cgw_pkg::weekday_ms(wday_s4) + tp3_q;

  logic [cgw_pkg::WeekW-1:0] week4_q;
  logic [cgw_pkg::TowW-1:0]  tow4_q;
  logic                      bad4_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage data registers
  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      year1_q    <= in_i.year;
      month1_q   <= in_i.month;
      day1_q     <= in_i.day;
      bad1_q     <= fbad_s1;
      qn1_q      <= qn_prod[24:cgw_pkg::Recip100Shift];
      qy1_q      <= qy_prod[24:cgw_pkg::Recip100Shift];
      hour_ms1_q <= hour_ms_s1;
      min_ms1_q  <= min_ms_s1;
      sec1_q     <= in_i.second_ms;
    end
    if (en2 && v1_q) begin
      days2_q <= days_s2;
      tp2_q   <= tp_s2;
      bad2_q  <= bad1_q;
    end
    if (en3 && v2_q) begin
      week3_q <= wprod[cgw_pkg::Recip7Shift+cgw_pkg::WeekW-1:cgw_pkg::Recip7Shift];
      d63_q   <= d6_s3;
      tp3_q   <= tp2_q;
      bad3_q  <= bad2_q || before_s3;
    end
    if (en4 && v3_q) begin
      week4_q <= bad3_q ? '0 : week3_q;
      tow4_q  <= bad3_q ? '0 : tow_s4;
      bad4_q  <= bad3_q;
    end
  end

  assign out_o.valid        = v4_q;
  assign out_o.gps_week     = week4_q;
  assign out_o.week_time_ms = tow4_q;
  assign out_o.date_invalid = bad4_q;

`ifndef ASSERT_OFF
  // A rejected date carries zero week and time of week
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && bad4_q) |-> (week4_q == '0 && tow4_q == '0))
    else $error("invalid result with nonzero fields");

  // The reciprocal division by 7 leaves a weekday in 0..6
  a_wday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !bad3_q) |-> (wday_s4 != 3'd7))
    else $error("weekday remainder out of range");

  // An accepted transaction occupies stage 1 on the next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted transaction lost at stage 1");

  // Input backpressure only when the whole pipe is full and the output stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // A result held by a stalled output stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_o.ready) |=> (v4_q && $stable(week4_q) && $stable(tow4_q)))
    else $error("stalled result changed");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the calendar date to GPS week and time-of-week converter.
`timescale 1ns / 1ps

// One calendar date/time as carried by the input channel
typedef struct {
  logic [cgw_pkg::YearW-1:0]   year;
  logic [cgw_pkg::MonthW-1:0]  month;
  logic [cgw_pkg::DayW-1:0]    day;
  logic [cgw_pkg::HourW-1:0]   hour;
  logic [cgw_pkg::MinuteW-1:0] minute;
  logic [cgw_pkg::SecMsW-1:0]  second_ms;
} date_t;

// One GPS time as carried by the output channel
typedef struct {
  logic [cgw_pkg::WeekW-1:0] week;
  logic [cgw_pkg::TowW-1:0]  tow;
  logic                      invalid;
} gps_time_t;

// Predicts the GPS time of each accepted date and checks results in order
class gps_scoreboard;
  localparam int unsigned FirstYear  = 1980;
  localparam int unsigned FirstDay   = 6;     // 6 Jan 1980 starts week zero
  localparam int unsigned DayMs      = 86400000;
  localparam int unsigned HourMs     = 3600000;
  localparam int unsigned MinuteMs   = 60000;
  localparam int unsigned MaxShown   = 100;

  gps_time_t   gps_q[$];
  int unsigned mismatches;
  int unsigned converted;
  int unsigned rejected;
  int unsigned checked;

  function new();
    mismatches = 0;
    converted  = 0;
    rejected   = 0;
    checked    = 0;
  endfunction

  // Gregorian leap rule
  function bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Number of leap years in 1..n
  function int unsigned leaps_thru(int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Days before the first of a month in a common year
  function int unsigned month_offset(logic [cgw_pkg::MonthW-1:0] m);
    case (m)
      4'd2:    return 31;
      4'd3:    return 59;
      4'd4:    return 90;
      4'd5:    return 120;
      4'd6:    return 151;
      4'd7:    return 181;
      4'd8:    return 212;
      4'd9:    return 243;
      4'd10:   return 273;
      4'd11:   return 304;
      4'd12:   return 334;
      default: return 0;
    endcase
  endfunction

  function gps_time_t to_gps(date_t d);
    gps_time_t   r;
    int unsigned y;
    int unsigned days;
    int unsigned ms;
    r.week    = '0;
    r.tow     = '0;
    r.invalid = 1'b1;
    y = d.year;
    // out-of-range year, month or day
    if (y < FirstYear || d.month < 1 || d.month > 12 || d.day < 1 || d.day > 31)
      return r;
    days = 365 * (y - FirstYear) + leaps_thru(y - 1) - leaps_thru(FirstYear - 1);
    days += month_offset(d.month);
    if (d.month > 2 && leap_year(y))
      days += 1;
    days += d.day;
    // first days of 1980 precede the epoch
    if (days < FirstDay)
      return r;
    days -= FirstDay;
    // hour, minute and second are summed unchecked
    ms = (days % 7) * DayMs + int'(d.hour) * HourMs + int'(d.minute) * MinuteMs
       + int'(d.second_ms);
    r.week    = cgw_pkg::WeekW'(days / 7);
    r.tow     = cgw_pkg::TowW'(ms);
    r.invalid = 1'b0;
    return r;
  endfunction

  function int unsigned pending();
    return gps_q.size();
  endfunction

  // Input transaction accepted: queue its expected GPS time
  function void note(date_t d);
    gps_time_t g;
    g = to_gps(d);
    converted++;
    if (g.invalid)
      rejected++;
    gps_q.push_back(g);
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= MaxShown)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Output transaction accepted: compare with the oldest expected GPS time
  task check(gps_time_t got);
    gps_time_t want;
    if (gps_q.size() == 0) begin
      report($sformatf("result with nothing pending: week=%0d tow=%0d invalid=%0b",
                       got.week, got.tow, got.invalid));
      return;
    end
    want = gps_q.pop_front();
    checked++;
    if (got.week !== want.week || got.tow !== want.tow || got.invalid !== want.invalid)
      report($sformatf("week %0d/%0d tow %0d/%0d invalid %0b/%0b (got/want)",
                       got.week, want.week, got.tow, want.tow, got.invalid, want.invalid));
  endtask
endclass

module tb_top;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned MaxIdle     = 18;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i;
  logic rst_ni;

  cgw_in_if  in_if ();
  cgw_out_if out_if ();

  calendar_to_gps_week_time u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gps_scoreboard sb;
  date_t         seen_date;
  gps_time_t     seen_gps;
  int unsigned   sent;
  int unsigned   holds;
  int unsigned   cycle_cnt;
  bit            src_calm;

  // Clock, 4 ns period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("FAIL");
    $finish;
  end

  // Monitor both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen_date = '{in_if.year, in_if.month, in_if.day, in_if.hour, in_if.minute,
                    in_if.second_ms};
      sb.note(seen_date);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_gps = '{out_if.gps_week, out_if.week_time_ms, out_if.date_invalid};
      sb.check(seen_gps);
    end
  end

  // Result side: random stalls, with calm stretches
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 64 == 0)
        calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, MaxIdle);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      taken++;
      @(negedge clk_i);
    end
  end

  function automatic date_t mk_date(int unsigned y, int unsigned m, int unsigned d,
                                    int unsigned h, int unsigned mi, int unsigned s);
    date_t r;
    r.year      = cgw_pkg::YearW'(y);
    r.month     = cgw_pkg::MonthW'(m);
    r.day       = cgw_pkg::DayW'(d);
    r.hour      = cgw_pkg::HourW'(h);
    r.minute    = cgw_pkg::MinuteW'(mi);
    r.second_ms = cgw_pkg::SecMsW'(s);
    return r;
  endfunction

  // Mostly well-formed dates, some raw noise over the full field ranges
  function automatic date_t random_date();
    date_t r;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      r.year      = (kind < 30) ? cgw_pkg::YearW'($urandom_range(1980, 2100))
                                : cgw_pkg::YearW'($urandom_range(1980, 4095));
      r.month     = cgw_pkg::MonthW'($urandom_range(1, 12));
      r.day       = cgw_pkg::DayW'($urandom_range(1, 31));
      r.hour      = cgw_pkg::HourW'($urandom_range(0, 23));
      r.minute    = cgw_pkg::MinuteW'($urandom_range(0, 59));
      r.second_ms = cgw_pkg::SecMsW'($urandom_range(0, 60999));
    end else begin
      r.year      = cgw_pkg::YearW'($urandom);
      r.month     = cgw_pkg::MonthW'($urandom);
      r.day       = cgw_pkg::DayW'($urandom);
      r.hour      = cgw_pkg::HourW'($urandom);
      r.minute    = cgw_pkg::MinuteW'($urandom);
      r.second_ms = cgw_pkg::SecMsW'($urandom);
    end
    return r;
  endfunction

  // Drive one date; hold waits for the pipeline to drain first
  task automatic send_date(input date_t d, input bit hold);
    int unsigned gap;
    if (sent % 64 == 0)
      src_calm = ($urandom_range(0, 3) == 0);
    gap = src_calm ? 0 : $urandom_range(0, MaxIdle);
    if (hold || gap > 0) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while (hold && sb.pending() != 0);
      repeat ((gap > 0) ? gap - 1 : 0) @(negedge clk_i);
      if (hold)
        holds++;
    end
    in_if.valid     <= 1'b1;
    in_if.year      <= d.year;
    in_if.month     <= d.month;
    in_if.day       <= d.day;
    in_if.hour      <= d.hour;
    in_if.minute    <= d.minute;
    in_if.second_ms <= d.second_ms;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin : stimulus
    sb       = new();
    sent     = 0;
    holds    = 0;
    src_calm = 1'b0;
    rst_ni   = 1'b0;
    in_if.valid     = 1'b0;
    in_if.year      = '0;
    in_if.month     = '0;
    in_if.day       = '0;
    in_if.hour      = '0;
    in_if.minute    = '0;
    in_if.second_ms = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, epoch edges, leap rules, unchecked fields
    send_date(mk_date(0, 0, 0, 0, 0, 0), 1'b0);
    send_date(mk_date(1979, 12, 31, 23, 59, 59999), 1'b0);
    send_date(mk_date(1980, 1, 1, 0, 0, 0), 1'b0);
    send_date(mk_date(1980, 1, 5, 23, 59, 60999), 1'b0);
    send_date(mk_date(1980, 1, 6, 0, 0, 0), 1'b0);
    send_date(mk_date(1980, 1, 12, 23, 59, 60999), 1'b0);
    send_date(mk_date(1980, 1, 13, 0, 0, 1), 1'b0);
    send_date(mk_date(2000, 0, 10, 1, 1, 1), 1'b0);
    send_date(mk_date(2000, 13, 10, 1, 1, 1), 1'b0);
    send_date(mk_date(4095, 15, 31, 31, 63, 65535), 1'b0);
    send_date(mk_date(2000, 5, 0, 1, 1, 1), 1'b0);
    send_date(mk_date(2000, 2, 29, 12, 0, 0), 1'b0);
    send_date(mk_date(2000, 3, 1, 12, 0, 0), 1'b0);
    send_date(mk_date(2100, 2, 29, 0, 0, 0), 1'b0);
    send_date(mk_date(2100, 3, 1, 0, 0, 0), 1'b0);
    send_date(mk_date(2400, 3, 1, 0, 0, 0), 1'b0);
    send_date(mk_date(2023, 2, 31, 6, 30, 30500), 1'b0);
    send_date(mk_date(2024, 12, 31, 23, 59, 59999), 1'b0);
    send_date(mk_date(1999, 8, 22, 0, 0, 0), 1'b0);
    send_date(mk_date(2019, 4, 7, 0, 0, 0), 1'b0);
    send_date(mk_date(2020, 6, 13, 31, 63, 65535), 1'b0);
    send_date(mk_date(4095, 12, 31, 31, 63, 65535), 1'b0);
    send_date(mk_date(4095, 1, 1, 0, 0, 0), 1'b0);

    // Random, with a drain hold now and then
    for (int unsigned i = 0; i < RandomItems; i++)
      send_date(random_date(), (i % 400 == 0));
    in_if.valid <= 1'b0;

    // Wait for the last results, then a few more cycles for strays
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Converted %0d dates (%0d rejected as invalid), %0d results checked.",
             sb.converted, sb.rejected, sb.checked);
    $display("Sender drained the pipeline %0d times; both sides idled 0 to %0d cycles.",
             holds, MaxIdle);
    if (sb.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
